// ===== rtl/afr_pkg.sv =====
// Shared types, character codes and helpers for the frame receiver.
package afr_pkg;

    // Framing and control characters on the link.
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_ETB = 8'h17;

    // Event codes reported for each byte.
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_ENQ      = 3'd1,
        EV_ACK      = 3'd2,
        EV_NAK      = 3'd3,
        EV_EOT      = 3'd4,
        EV_FRAME_OK = 3'd5,
        EV_CSUM_BAD = 3'd6,
        EV_NO_STX   = 3'd7
    } event_t;

    // Which end marker currently governs the checksum.
    typedef enum logic [1:0] {
        MK_NONE = 2'd0,
        MK_ETB  = 2'd1,
        MK_ETX  = 2'd2
    } marker_t;

    // One result transaction.
    typedef struct packed {
        event_t     event_res;
        logic [7:0] frame_sum;
        logic [7:0] check_high;
        logic [7:0] check_low;
    } result_t;

    // Uppercase ASCII hex digit for one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] code;
        if (nib < 4'd10) begin
            code = 8'h30 + {4'd0, nib};
        end else begin
            code = 8'h37 + {4'd0, nib};
        end
        return code;
    endfunction

endpackage

// ===== rtl/afr_core.sv =====
// Frame state tracking, modulo-256 summing and checksum comparison.
module afr_core
    import afr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    logic       in_frame_reg,    in_frame_next;
    logic       started_ok_reg,  started_ok_next;
    logic       end_phase_reg,   end_phase_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] latched_sum_reg, latched_sum_next;
    marker_t    marker_reg,      marker_next;
    logic [1:0] cap_count_reg,   cap_count_next;
    logic [7:0] cap0_reg,        cap0_next;
    logic [7:0] cap1_reg,        cap1_next;
    logic       frame_ends;
    logic       csum_match;

    // Next state and the result for the byte presented this cycle.
    always_comb begin
        in_frame_next    = in_frame_reg;
        started_ok_next  = started_ok_reg;
        end_phase_next   = end_phase_reg;
        running_sum_next = running_sum_reg;
        latched_sum_next = latched_sum_reg;
        marker_next      = marker_reg;
        cap_count_next   = cap_count_reg;
        cap0_next        = cap0_reg;
        cap1_next        = cap1_reg;
        frame_ends       = 1'b0;
        csum_match       = 1'b0;
        result           = '{event_res: EV_NONE, frame_sum: 8'd0,
                             check_high: 8'd0, check_low: 8'd0};

        if (!in_frame_reg) begin
            unique case (rx_byte)
                CH_ENQ: begin
                    result.event_res = EV_ENQ;
                end
                CH_ACK: begin
                    result.event_res = EV_ACK;
                end
                CH_NAK: begin
                    result.event_res = EV_NAK;
                end
                CH_EOT: begin
                    result.event_res = EV_EOT;
                end
                default: begin
                    // Any other byte opens a frame.
                    in_frame_next    = 1'b1;
                    started_ok_next  = (rx_byte == CH_STX);
                    end_phase_next   = 1'b0;
                    running_sum_next = 8'd0;
                    latched_sum_next = 8'd0;
                    marker_next      = MK_NONE;
                    cap_count_next   = 2'd2;
                    cap0_next        = 8'd0;
                    cap1_next        = 8'd0;
                    if (rx_byte == CH_ETX) begin
                        end_phase_next = 1'b1;
                        marker_next    = MK_ETX;
                        cap_count_next = 2'd0;
                    end else if (rx_byte == CH_ETB) begin
                        end_phase_next = 1'b1;
                        marker_next    = MK_ETB;
                        cap_count_next = 2'd0;
                    end
                end
            endcase
        end else begin
            // Capture the characters that follow the governing marker.
            if (cap_count_reg < 2'd2) begin
                if (cap_count_reg[0]) begin
                    cap1_next = rx_byte;
                end else begin
                    cap0_next = rx_byte;
                end
                cap_count_next = cap_count_reg + 2'd1;
            end
            running_sum_next = running_sum_reg + rx_byte;

            // Marker handling; ETX restarts the capture, ETB only while no ETX has come.
            if (rx_byte == CH_STX) begin
                end_phase_next = 1'b0;
            end else if (rx_byte == CH_ETX) begin
                end_phase_next   = 1'b1;
                marker_next      = MK_ETX;
                latched_sum_next = running_sum_next;
                cap_count_next   = 2'd0;
                cap0_next        = 8'd0;
                cap1_next        = 8'd0;
            end else if (rx_byte == CH_ETB) begin
                end_phase_next = 1'b1;
                if (marker_reg != MK_ETX) begin
                    marker_next      = MK_ETB;
                    latched_sum_next = running_sum_next;
                    cap_count_next   = 2'd0;
                    cap0_next        = 8'd0;
                    cap1_next        = 8'd0;
                end
            end else if (rx_byte == CH_LF && end_phase_reg) begin
                frame_ends = 1'b1;
            end

            // Frame end: verify the checksum and return to idle.
            if (frame_ends) begin
                csum_match = (cap0_next == hex_char(latched_sum_reg[7:4])) &&
                             (cap1_next == hex_char(latched_sum_reg[3:0]));
                if (!started_ok_reg) begin
                    result.event_res = EV_NO_STX;
                end else begin
                    result.event_res  = csum_match ? EV_FRAME_OK : EV_CSUM_BAD;
                    result.frame_sum  = latched_sum_reg;
                    result.check_high = cap0_next;
                    result.check_low  = cap1_next;
                end
                in_frame_next    = 1'b0;
                started_ok_next  = 1'b0;
                end_phase_next   = 1'b0;
                running_sum_next = 8'd0;
                marker_next      = MK_NONE;
                cap_count_next   = 2'd0;
            end
        end
    end

    // State registers advance once per processed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg    <= 1'b0;
            started_ok_reg  <= 1'b0;
            end_phase_reg   <= 1'b0;
            running_sum_reg <= 8'd0;
            latched_sum_reg <= 8'd0;
            marker_reg      <= MK_NONE;
            cap_count_reg   <= 2'd0;
            cap0_reg        <= 8'd0;
            cap1_reg        <= 8'd0;
        end else if (step) begin
            in_frame_reg    <= in_frame_next;
            started_ok_reg  <= started_ok_next;
            end_phase_reg   <= end_phase_next;
            running_sum_reg <= running_sum_next;
            latched_sum_reg <= latched_sum_next;
            marker_reg      <= marker_next;
            cap_count_reg   <= cap_count_next;
            cap0_reg        <= cap0_next;
            cap1_reg        <= cap1_next;
        end
    end

endmodule

// ===== rtl/astm_frame_receiver.sv =====
// Top level of the frame receiver: input register, frame core and result register.
// An accepted byte waits in the input register; its result is registered for m_*.
// Throughput: one byte per cycle while m_ready does not stall the output.
// The input register accepts a new transaction while a result waits on the output.
// Reset (aresetn, synchronous, active low) empties both registers and returns the
// frame state to idle with a zero sum and no marker.
module astm_frame_receiver
    import afr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [7:0] m_frame_sum,
    output logic [7:0] m_check_high,
    output logic [7:0] m_check_low
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    core_result;
    logic       advance;

    // The held byte moves into the result register when that register can load.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    afr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (core_result)
    );

    // Valid flags of the two registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_res  = out_result_reg.event_res;
    assign m_frame_sum  = out_result_reg.frame_sum;
    assign m_check_high = out_result_reg.check_high;
    assign m_check_low  = out_result_reg.check_low;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the frame receiver: directed frames, then random byte traffic.
module tb_top;
    import afr_pkg::*;

    // Cycles without any accepted transaction before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_BYTES_PER_PHASE = 175;
    localparam logic [7:0] CH_CR = 8'h0D;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_event_res;
    logic [7:0] m_frame_sum;
    logic [7:0] m_check_high;
    logic [7:0] m_check_low;

    // Traffic shaping for the current phase, in percent.
    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Events predicted for accepted bytes, oldest first.
    result_t pending_events[$];

    // Predicted receiver state.
    logic       f_open;
    logic       f_stx;
    logic       f_armed;
    logic [7:0] f_sum;
    logic [7:0] f_latched;
    marker_t    f_marker;
    logic [1:0] f_ncap;
    logic [7:0] f_chars[2];

    astm_frame_receiver u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res),
        .m_frame_sum (m_frame_sum),
        .m_check_high(m_check_high),
        .m_check_low (m_check_low)
    );

    always #4 aclk = ~aclk;

    // Uppercase ASCII hex digit of one nibble.
    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'h0, nib};
        end
        return 8'h41 + {4'h0, nib} - 8'd10;
    endfunction

    // The current sum now governs the checksum; capture starts afresh.
    function automatic void restart_capture();
        f_latched = f_sum;
        f_ncap = 2'd0;
        f_chars[0] = 8'h00;
        f_chars[1] = 8'h00;
    endfunction

    // Advance the predicted state by one byte and return the event it causes.
    function automatic result_t next_event(input logic [7:0] b);
        result_t r;
        r = '0;
        if (!f_open) begin
            case (b)
                CH_ENQ: r.event_res = EV_ENQ;
                CH_ACK: r.event_res = EV_ACK;
                CH_NAK: r.event_res = EV_NAK;
                CH_EOT: r.event_res = EV_EOT;
                default: begin
                    // Any other byte opens a frame, flagged unless it is STX.
                    f_open = 1'b1;
                    f_stx = (b == CH_STX);
                    f_armed = 1'b0;
                    f_sum = 8'h00;
                    f_latched = 8'h00;
                    f_marker = MK_NONE;
                    f_ncap = 2'd2;
                    f_chars[0] = 8'h00;
                    f_chars[1] = 8'h00;
                    if (!f_stx && (b == CH_ETX || b == CH_ETB)) begin
                        f_armed = 1'b1;
                        f_marker = (b == CH_ETX) ? MK_ETX : MK_ETB;
                        restart_capture();
                    end
                end
            endcase
        end else begin
            // Capture happens before the byte is looked at as a marker.
            if (f_ncap < 2'd2) begin
                f_chars[f_ncap[0]] = b;
                f_ncap = f_ncap + 2'd1;
            end
            f_sum = f_sum + b;
            if (b == CH_STX) begin
                f_armed = 1'b0;
            end else if (b == CH_ETX) begin
                f_armed = 1'b1;
                f_marker = MK_ETX;
                restart_capture();
            end else if (b == CH_ETB) begin
                f_armed = 1'b1;
                if (f_marker != MK_ETX) begin
                    f_marker = MK_ETB;
                    restart_capture();
                end
            end else if (b == CH_LF && f_armed) begin
                // End of frame: judge the captured characters.
                if (!f_stx) begin
                    r.event_res = EV_NO_STX;
                end else begin
                    r.event_res = (f_chars[0] == ascii_hex(f_latched[7:4]) &&
                                   f_chars[1] == ascii_hex(f_latched[3:0]))
                                  ? EV_FRAME_OK : EV_CSUM_BAD;
                    r.frame_sum = f_latched;
                    r.check_high = f_chars[0];
                    r.check_low = f_chars[1];
                end
                f_open = 1'b0;
                f_stx = 1'b0;
                f_armed = 1'b0;
                f_sum = 8'h00;
                f_marker = MK_NONE;
                f_ncap = 2'd0;
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            if (mismatches < 10) begin
                $display("mismatch on %s: expected %02h, got %02h", name, want, got);
            end
            mismatches++;
        end
    endfunction

    // Offer one byte, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_events.push_back(next_event(b));
        bytes_sent++;
    endtask

    // A frame opened by STX with random content, usually with a correct checksum.
    task automatic send_random_frame();
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        int n;
        n = $urandom_range(8, 0);
        sum = 8'h00;
        send_byte(CH_STX);
        repeat (n) begin
            b = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(8'h7E, 8'h20));
            sum = sum + b;
            send_byte(b);
        end
        b = ($urandom_range(2) == 0) ? CH_ETB : CH_ETX;
        sum = sum + b;
        send_byte(b);
        // Now and then the frame is cut short right after the marker.
        if ($urandom_range(9) != 0) begin
            hi = ascii_hex(sum[7:4]);
            lo = ascii_hex(sum[3:0]);
            if ($urandom_range(4) == 0) begin
                hi = hi ^ (8'h01 << $urandom_range(7));
            end
            if ($urandom_range(4) == 0) begin
                lo = lo ^ (8'h01 << $urandom_range(7));
            end
            send_byte(hi);
            send_byte(lo);
            if ($urandom_range(1) == 0) begin
                send_byte(CH_CR);
            end
        end
        send_byte(CH_LF);
    endtask

    // A control byte, or random bytes closed off by ETX and LF.
    task automatic send_noise();
        int n;
        if ($urandom_range(9) < 7) begin
            case ($urandom_range(3))
                0: send_byte(CH_ENQ);
                1: send_byte(CH_ACK);
                2: send_byte(CH_NAK);
                default: send_byte(CH_EOT);
            endcase
        end else begin
            n = $urandom_range(4, 1);
            repeat (n) begin
                send_byte(8'($urandom_range(255)));
            end
            send_byte(CH_ETX);
            send_byte(CH_LF);
        end
    endtask

    task automatic test_control_bytes();
        send_byte(CH_ENQ);
        send_byte(CH_ACK);
        send_byte(CH_NAK);
        send_byte(CH_EOT);
    endtask

    task automatic test_checksum_frames();
        // ETX frame with an all-ones data byte; sum 02h.
        send_byte(CH_STX); send_byte(8'hFF); send_byte(CH_ETX);
        send_byte(8'h30); send_byte(8'h32); send_byte(CH_LF);
        // ETB frame carrying ENQ as data; sum 1Ch.
        send_byte(CH_STX); send_byte(CH_ENQ); send_byte(CH_ETB);
        send_byte(8'h31); send_byte(8'h43); send_byte(CH_LF);
    endtask

    task automatic test_frame_corner_cases();
        // Frame opened by a zero byte instead of STX.
        send_byte(8'h00); send_byte(CH_ETX); send_byte(CH_LF);
        // Frame that ends before both checksum characters arrive.
        send_byte(CH_STX); send_byte(CH_ETX); send_byte(CH_LF);
        // STX inside the frame cancels the pending end; ETB after ETX does not relatch.
        send_byte(CH_STX); send_byte(CH_ETX); send_byte(CH_STX);
        send_byte(CH_LF); send_byte(CH_ETB); send_byte(CH_LF);
    endtask

    task automatic test_random_traffic(input int idle, input int stall);
        int target;
        idle_pct = idle;
        stall_pct = stall;
        target = bytes_sent + RANDOM_BYTES_PER_PHASE;
        while (bytes_sent < target) begin
            if ($urandom_range(3) == 0) begin
                send_noise();
            end else begin
                send_random_frame();
            end
        end
    endtask

    // Result side: compare each transaction with the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result: event %0d", m_event_res);
                end
                mismatches++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_res", {5'b0, want.event_res}, {5'b0, m_event_res});
                check_field("frame_sum", want.frame_sum, m_frame_sum);
                check_field("check_high", want.check_high, m_check_high);
                check_field("check_low", want.check_low, m_check_low);
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        f_open = 1'b0;
        f_stx = 1'b0;
        f_armed = 1'b0;
        f_sum = 8'h00;
        f_latched = 8'h00;
        f_marker = MK_NONE;
        f_ncap = 2'd0;
        f_chars[0] = 8'h00;
        f_chars[1] = 8'h00;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_control_bytes();
        test_checksum_frames();
        test_frame_corner_cases();
        test_random_traffic(0, 0);
        test_random_traffic(81, 0);
        test_random_traffic(0, 81);
        test_random_traffic(11, 11);

        // Drain the outstanding results, then allow for the pipeline depth.
        s_valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/afr_pkg.sv
rtl/afr_core.sv
rtl/astm_frame_receiver.sv
tb/tb_top.sv
